>>> rtl/aes_pkg.sv
// Package for the AES-128 block cipher: command codes, the S-box table and
// the byte, row and column transforms of one round. No dependencies.
`default_nettype none
package aes_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [7:0] GF_REDUCE = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Inverse affine map; the S-box is affine(inverse), so the inverse S-box is
  // inverse_affine(sbox(inverse_affine(y))) and needs no table of its own.
  function automatic logic [7:0] inv_affine(input logic [7:0] y);
    return rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05;
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] y);
    return inv_affine(SBOX[inv_affine(y)]);
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ((a << 1) ^ GF_REDUCE) : (a << 1);
  endfunction

  // Byte k of a block sits at bits [127-8k -: 8]; byte k is row k%4, column k/4.
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inverse);
    logic [127:0] t;
    for (int k = 0; k < 16; k++) begin
      t[127-8*k -: 8] = inverse ? inv_sbox(s[127-8*k -: 8]) : SBOX[s[127-8*k -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inverse);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = inverse ? s[127-8*(r+4*((c+4-r)%4)) -: 8]
                                        : s[127-8*(r+4*((c+r)%4)) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inverse);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m4 [4];
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      // m1..m4 are the products by the matrix row entries {2,3,1,1} or {14,11,13,9}.
      m1[k] = inverse ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
      m2[k] = inverse ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
      m3[k] = inverse ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
      m4[k] = inverse ? (x8[k] ^ a[k]) : a[k];
    end
    for (int r = 0; r < 4; r++) begin
      o[31-8*r -: 8] = m1[r] ^ m2[(r+1)%4] ^ m3[(r+2)%4] ^ m4[(r+3)%4];
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inverse);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inverse);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/aes128_block_cipher.sv
// AES-128 block cipher top level: key store, round unit and sequencer.
// Depends on aes_pkg.
`default_nettype none
// One input word carries a command in tuser. A load command writes one 32-bit
// round-key word into the key store (an index beyond the store is dropped) and
// returns nothing. An encrypt or decrypt command takes a 128-bit block and
// returns one output word with the 128-bit result. The key store must be
// loaded before use; no key expansion happens here. For a block, the first
// round key is read at the accepting edge, the initial key add follows in
// S_INIT, and then each round runs in S_RUN through the single shared round
// unit, which reads one 128-bit row of round keys a cycle from the key store.
// The input stays not ready from acceptance of a block until its result is
// taken, so no new block or load is accepted while one is in progress.
// A load command leaves the input ready. Command value 3 is dropped.
module aes128_block_cipher #(
  parameter int ROUNDS = 10
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata, lowest bit up: key_index[5:0], key_word[37:6], block_high[101:38],
  // block_low[165:102], zero fill [167:166].
  input  wire logic [167:0] s_axis_tdata,
  // tuser: command[1:0].
  input  wire aes_pkg::cmd_t s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata, lowest bit up: result_high[63:0], result_low[127:64].
  output logic [127:0]      m_axis_tdata
);
  import aes_pkg::*;

  localparam int ROWS      = ROUNDS + 1;
  localparam int KEY_WORDS = 4 * ROWS;
  localparam int RW        = $clog2(ROWS);
  localparam int CW        = $clog2(ROUNDS + 2);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_RUN, S_DONE} state_t;

  state_t        state;
  logic          dec;
  logic [CW-1:0] cnt;
  logic [127:0]  st;
  logic [127:0]  key_q;
  logic [127:0]  kmem [ROWS];

  logic [5:0]    key_index;
  logic [31:0]   key_word;
  logic [63:0]   block_high;
  logic [63:0]   block_low;
  logic          accept;
  logic          dec_sel;
  logic [CW-1:0] step;
  logic [CW-1:0] step_c;
  logic [RW-1:0] raddr;
  logic [1:0]    lane;
  logic          last;
  logic [127:0]  rnd_out;

  assign key_index  = s_axis_tdata[5:0];
  assign key_word   = s_axis_tdata[37:6];
  assign block_high = s_axis_tdata[101:38];
  assign block_low  = s_axis_tdata[165:102];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign lane          = 2'd3 - key_index[1:0];

  // Key row for the next step; decryption walks the rows from the top down.
  always_comb begin
    dec_sel = (state == S_IDLE) ? (s_axis_tuser == CMD_DECRYPT) : dec;
    step    = (state == S_IDLE) ? '0 : CW'(cnt + 1'b1);
    step_c  = (step > CW'(ROUNDS)) ? CW'(ROUNDS) : step;
    raddr   = dec_sel ? RW'(CW'(ROUNDS) - step_c) : RW'(step_c);
  end

  // The shared round unit; the last round skips the column mix.
  always_comb begin
    last = (cnt == CW'(ROUNDS));
    if (!dec) begin
      rnd_out = shift_rows(sub_bytes(st, 1'b0), 1'b0);
      if (!last) rnd_out = mix_columns(rnd_out, 1'b0);
      rnd_out = rnd_out ^ key_q;
    end else begin
      rnd_out = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ key_q;
      if (!last) rnd_out = mix_columns(rnd_out, 1'b1);
    end
  end

  // Key store: one 128-bit row per round, written a word at a time.
  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser == CMD_LOAD && key_index < 6'(KEY_WORDS)) begin
      kmem[key_index[2 +: RW]][32*lane +: 32] <= key_word;
    end
    key_q <= kmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (s_axis_tuser == CMD_ENCRYPT || s_axis_tuser == CMD_DECRYPT)) begin
            state <= S_INIT;
            dec   <= (s_axis_tuser == CMD_DECRYPT);
            cnt   <= '0;
            st    <= {block_high, block_low};
          end
        end
        S_INIT: begin
          st    <= st ^ key_q;
          cnt   <= CW'(1);
          state <= S_RUN;
        end
        S_RUN: begin
          st  <= rnd_out;
          cnt <= CW'(cnt + 1'b1);
          if (last) begin
            m_axis_tdata  <= {rnd_out[63:0], rnd_out[127:64]};
            m_axis_tvalid <= 1'b1;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/aes_chk.sv
// Port-level checks for the AES-128 block cipher, bound to its top level.
// No package dependency.
`default_nettype none
module aes_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [1:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata
);

  // A pending result holds its word until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  // No new word is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while a result is pending");

  // A block command makes the input busy at once.
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == 2'd1 || s_axis_tuser == 2'd2)
    |=> !s_axis_tready)
    else $error("input still ready after a block command");

  // A result appears only after a busy cycle.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a block in progress");

endmodule

bind aes128_block_cipher aes_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for aes128_block_cipher: loads round keys, then
// streams encrypt, decrypt, load and ignored commands against its own AES model.
// Depends on aes_pkg and the aes128_block_cipher RTL.
`timescale 1ns / 100ps

module testbench;
  import aes_pkg::*;

  localparam int NUM_KEYS = 44;
  localparam int RANDOM_WORDS = 1700;

  typedef logic [7:0] state_t [16];

  typedef struct {
    cmd_t        cmd;
    logic [5:0]  idx;
    logic [31:0] kw;
    logic [63:0] bhi;
    logic [63:0] blo;
    bit          drain;
  } word_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  cmd_t s_axis_tuser = CMD_LOAD;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  aes128_block_cipher dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Pending words for the driver and blocks the cipher still owes us.
  word_t  word_q[$];
  block_t cipher_due[$];
  word_t  cur;

  logic [31:0] key_mem [NUM_KEYS];
  logic [7:0]  sbox_fwd [256];
  logic [7:0]  sbox_rev [256];

  int n_accepted = 0;
  int n_total = 0;
  int n_blocks = 0;
  int n_loads = 0;
  int n_dropped = 0;
  int n_checked = 0;
  int failures = 0;
  int hold_left = 0;
  bit hold_done = 0;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 0;
    for (int n = 0; n < 8; n++) begin
      if (b[0]) acc ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic state_t key_mix(input state_t s, input int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = key_mem[4 * rnd + c];
      for (int r = 0; r < 4; r++) s[4 * c + r] ^= w[31 - 8 * r -: 8];
    end
    return s;
  endfunction

  function automatic state_t byte_sub(input state_t s, input bit inv);
    for (int i = 0; i < 16; i++) s[i] = inv ? sbox_rev[s[i]] : sbox_fwd[s[i]];
    return s;
  endfunction

  function automatic state_t row_shift(input state_t s, input bit inv);
    state_t t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r + 4 * c] = inv ? s[r + 4 * ((c + 4 - r) % 4)] : s[r + 4 * ((c + r) % 4)];
    return t;
  endfunction

  function automatic state_t col_mix(input state_t s, input bit inv);
    logic [7:0] coef [4];
    state_t t;
    logic [7:0] v;
    if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        v = 0;
        for (int k = 0; k < 4; k++) v ^= gmul(coef[(k + 4 - r) % 4], s[4 * c + k]);
        t[4 * c + r] = v;
      end
    return t;
  endfunction

  // Full cipher or inverse cipher over the loaded key schedule.
  function automatic block_t aes_block(input word_t w);
    state_t s;
    block_t b;
    bit inv;
    inv = (w.cmd == CMD_DECRYPT);
    for (int k = 0; k < 8; k++) begin
      s[k] = w.bhi[63 - 8 * k -: 8];
      s[8 + k] = w.blo[63 - 8 * k -: 8];
    end
    if (!inv) begin
      s = key_mix(s, 0);
      for (int r = 1; r < 10; r++)
        s = key_mix(col_mix(row_shift(byte_sub(s, 0), 0), 0), r);
      s = key_mix(row_shift(byte_sub(s, 0), 0), 10);
    end else begin
      s = key_mix(s, 10);
      for (int r = 9; r > 0; r--)
        s = col_mix(key_mix(byte_sub(row_shift(s, 1), 1), r), 1);
      s = key_mix(byte_sub(row_shift(s, 1), 1), 0);
    end
    for (int k = 0; k < 8; k++) begin
      b.hi[63 - 8 * k -: 8] = s[k];
      b.lo[63 - 8 * k -: 8] = s[8 + k];
    end
    return b;
  endfunction

  // Applies one accepted word to the model state and queues its result.
  task automatic apply_word(input word_t w);
    case (w.cmd)
      CMD_LOAD: begin
        if (w.idx < NUM_KEYS) begin
          key_mem[w.idx] = w.kw;
          n_loads++;
        end else begin
          n_dropped++;
        end
      end
      CMD_ENCRYPT, CMD_DECRYPT: begin
        cipher_due.push_back(aes_block(w));
        n_blocks++;
      end
      default: n_dropped++;
    endcase
  endtask

  function automatic word_t make_word(input cmd_t cmd, input logic [5:0] idx,
                                      input logic [31:0] kw, input logic [63:0] bhi,
                                      input logic [63:0] blo);
    word_t w;
    w.cmd = cmd; w.idx = idx; w.kw = kw; w.bhi = bhi; w.blo = blo; w.drain = 0;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Idle and stall percentages follow four phases over the run:
  // none, sender idle, receiver stalling, then light idling on both.
  function automatic int phase_of();
    return (n_total == 0) ? 0 : (n_accepted * 4) / n_total;
  endfunction

  function automatic int send_idle();
    int p;
    p = phase_of();
    return (p == 1) ? 73 : (p == 3) ? 7 : 0;
  endfunction

  function automatic int recv_stall();
    int p;
    p = phase_of();
    return (p == 2) ? 73 : (p == 3) ? 7 : 0;
  endfunction

  // Driver: a word is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_word(cur);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() != 0 && (!word_q[0].drain || cipher_due.size() == 0) &&
            $urandom_range(99) >= send_idle()) begin
          cur = word_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {2'b00, cur.blo, cur.bhi, cur.kw, cur.idx};
          s_axis_tuser <= cur.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expected block.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_due.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          failures++;
        end else begin
          block_t exp_b;
          exp_b = cipher_due.pop_front();
          if (m_axis_tdata[63:0] !== exp_b.hi) begin
            $error("result_high: expected %h, got %h", exp_b.hi, m_axis_tdata[63:0]);
            failures++;
          end
          if (m_axis_tdata[127:64] !== exp_b.lo) begin
            $error("result_low: expected %h, got %h", exp_b.lo, m_axis_tdata[127:64]);
            failures++;
          end
          n_checked++;
        end
      end
      // One long hold-off while the sender keeps offering words.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_checked == 300) begin
        hold_done <= 1;
        hold_left <= 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall());
      end
    end
  end

  initial begin
    word_t w;
    int r;
    // Substitution tables from the field inverse and the affine map.
    for (int x = 0; x < 256; x++) begin
      logic [7:0] inv_x, b, y;
      inv_x = 1; b = x[7:0];
      for (int e = 254; e != 0; e = e >> 1) begin
        if (e & 1) inv_x = gmul(inv_x, b);
        b = gmul(b, b);
      end
      y = inv_x ^ rot8(inv_x, 1) ^ rot8(inv_x, 2) ^ rot8(inv_x, 3) ^ rot8(inv_x, 4) ^ 8'h63;
      sbox_fwd[x] = y;
      sbox_rev[y] = x[7:0];
    end

    // Whole key schedule first, so no unwritten key word is ever read.
    for (int i = 0; i < NUM_KEYS; i++)
      word_q.push_back(make_word(CMD_LOAD, i[5:0], $urandom, rand64(), rand64()));
    // Directed: extreme blocks both ways, extreme key words, dropped loads
    // beyond the store, and the unused command code.
    word_q.push_back(make_word(CMD_ENCRYPT, 6'd0, 32'd0, '0, '0));
    word_q.push_back(make_word(CMD_ENCRYPT, '1, '1, '1, '1));
    word_q.push_back(make_word(CMD_DECRYPT, 6'd0, 32'd0, '0, '0));
    word_q.push_back(make_word(CMD_DECRYPT, '1, '1, '1, '1));
    word_q.push_back(make_word(CMD_LOAD, 6'd0, 32'h0, '1, '1));
    word_q.push_back(make_word(CMD_LOAD, 6'd43, 32'hffff_ffff, '0, '0));
    word_q.push_back(make_word(CMD_LOAD, 6'd44, 32'hdead_beef, '0, '0));
    word_q.push_back(make_word(CMD_LOAD, 6'd63, 32'h1234_5678, '0, '0));
    word_q.push_back(make_word(CMD_NONE, 6'd5, '1, '1, '1));
    word_q.push_back(make_word(CMD_ENCRYPT, 6'd0, 32'd0, 64'h0011_2233_4455_6677,
                               64'h8899_aabb_ccdd_eeff));
    word_q.push_back(make_word(CMD_DECRYPT, 6'd0, 32'd0, 64'h0011_2233_4455_6677,
                               64'h8899_aabb_ccdd_eeff));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      r = $urandom_range(99);
      if (r < 40) w = make_word(CMD_ENCRYPT, 6'($urandom), $urandom, rand64(), rand64());
      else if (r < 75)
        w = make_word(CMD_DECRYPT, 6'($urandom), $urandom, rand64(), rand64());
      else if (r < 92)
        w = make_word(CMD_LOAD, 6'($urandom_range(NUM_KEYS - 1)), $urandom, rand64(),
                      rand64());
      else if (r < 96)
        w = make_word(CMD_LOAD, 6'($urandom_range(63, NUM_KEYS)), $urandom, rand64(),
                      rand64());
      else w = make_word(CMD_NONE, 6'($urandom), $urandom, rand64(), rand64());
      // Once mid-run the sender waits for every outstanding result.
      w.drain = (i == RANDOM_WORDS / 2);
      word_q.push_back(w);
    end
    n_total = word_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (word_q.size() != 0 || s_axis_tvalid || cipher_due.size() != 0);
    repeat (40) @(posedge clk);

    $display("Covered %0d cipher blocks checked, %0d key loads, %0d dropped words.",
             n_checked, n_loads, n_dropped);
    if (failures == 0 && cipher_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
